// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/pcpd_pkg.sv -----
package pcpd_pkg;

    localparam int CANVAS_WIDTH  = 128;
    localparam int CANVAS_HEIGHT = 128;
    localparam int SCALE         = 4;

    localparam int ROW_BYTES   = (CANVAS_WIDTH + 3) / 4;
    localparam int STORE_BYTES = ROW_BYTES * CANVAS_HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int WIN_W       = CANVAS_WIDTH * SCALE;
    localparam int WIN_H       = CANVAS_HEIGHT * SCALE;
    localparam int XW          = $clog2(CANVAS_WIDTH);
    localparam int YW          = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;

    // command codes
    localparam logic [2:0] FN_WRITE    = 3'd0;
    localparam logic [2:0] FN_CLEAR    = 3'd1;
    localparam logic [2:0] FN_FADE_OUT = 3'd2;
    localparam logic [2:0] FN_FADE_IN  = 3'd3;
    localparam logic [2:0] FN_TICK     = 3'd4;
    localparam logic [2:0] FN_READ     = 3'd5;

    // fade modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_OUT  = 2'd1;
    localparam logic [1:0] MODE_IN   = 2'd2;

    // config register indexes
    localparam int         CFG_AW        = 3;
    localparam logic [2:0] CFG_COLOR0    = 3'd0;
    localparam logic [2:0] CFG_COLOR1    = 3'd1;
    localparam logic [2:0] CFG_COLOR2    = 3'd2;
    localparam logic [2:0] CFG_COLOR3    = 3'd3;
    localparam logic [2:0] CFG_FADE_RATE = 3'd4;

    localparam logic [23:0] COLOR0_RST    = 24'h141414;
    localparam logic [23:0] COLOR1_RST    = 24'h9c1c28;
    localparam logic [23:0] COLOR2_RST    = 24'hedae49;
    localparam logic [23:0] COLOR3_RST    = 24'hebebeb;
    localparam logic [7:0]  FADE_RATE_RST = 8'd10;

    localparam logic [23:0] ACC_ONE      = 24'h010000;
    localparam logic [7:0]  MAP_IDENTITY = 8'b11100100;

    typedef struct packed {
        logic start_out;
        logic start_in;
        logic tick;
    } t_fade_cmd;

    typedef struct packed {
        logic [7:0] map;
        logic       fading;
    } t_fade_stat;

    function automatic logic [7:0] level_map(input logic [1:0] lvl);
        logic [7:0] m;
        case (lvl)
            2'd0: m = 8'b11100100;
            2'd1: m = 8'b10010000;
            2'd2: m = 8'b01000000;
            default: m = 8'b00000000;
        endcase
        return m;
    endfunction

endpackage

// ----- design/pcpd_in_if.sv -----
interface pcpd_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [1:0]         color_index;
    logic [15:0]        elapsed;

    modport source (output valid, func, pos_x, pos_y, color_index, elapsed, input ready);
    modport sink   (input valid, func, pos_x, pos_y, color_index, elapsed, output ready);
endinterface

// ----- design/pcpd_out_if.sv -----
interface pcpd_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] rgb;
    logic        fading;
    logic        outside;

    modport source (output valid, rgb, fading, outside, input ready);
    modport sink   (input valid, rgb, fading, outside, output ready);
endinterface

// ----- design/pcpd_cfg_if.sv -----
interface pcpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [23:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- design/packed_canvas_palette_display.sv -----
// Channel   Dir  Payload                                   Handshake
// i_in      in   func, pos_x, pos_y, color_index, elapsed  valid/ready
// o_out     out  rgb, fading, outside                      valid/ready
// i_cfg     in   addr (0..4), data                         valid/ready, always ready
//
// Fade, tick, clear start, clipped write, out-of-window read and unused commands
// finish in idle; in-canvas pixel write and in-window read also pass through the
// RMW or READ state, since the canvas RAM read is registered (the write is a
// read-modify-write of one byte). Clear then sweeps the RAM one byte per cycle
// over all STORE_BYTES (4096) bytes; no input is taken until it ends.
// Input is taken only when idle and the output register is empty or draining.
// Synchronous active-low reset clears control and config; canvas is not cleared.
`include "assert_macros.svh"

module packed_canvas_palette_display (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcpd_in_if.sink    i_in,
    pcpd_out_if.source o_out,
    pcpd_cfg_if.sink   i_cfg
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RMW   = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    localparam logic [pcpd_pkg::ADDR_W-1:0] LAST_ADDR =
        pcpd_pkg::ADDR_W'(pcpd_pkg::STORE_BYTES - 1);

    logic [1:0]                   r_state, n_state;
    logic [pcpd_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [pcpd_pkg::ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [1:0]                   r_sub, n_sub;
    logic [1:0]                   r_cidx, n_cidx;
    logic                         r_out_valid, n_out_valid;
    logic [23:0]                  r_out_rgb, n_out_rgb;
    logic                         r_out_fading, n_out_fading;
    logic                         r_out_outside, n_out_outside;
    logic [23:0]                  r_color [4];
    logic [7:0]                   r_fade_rate;

    logic                         in_acc;
    logic                         wr_inside, win_inside;
    logic [pcpd_pkg::XW-1:0]      cx;
    logic [pcpd_pkg::YW-1:0]      cy;
    logic [pcpd_pkg::ADDR_W-1:0]  acc_addr;

    logic                         ram_we;
    logic [pcpd_pkg::ADDR_W-1:0]  ram_waddr;
    logic [7:0]                   ram_wdata;
    logic [7:0]                   ram_rdata;
    logic [1:0]                   pix, mapped;

    pcpd_pkg::t_fade_cmd          fade_cmd;
    pcpd_pkg::t_fade_stat         fade_stat;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    assign wr_inside = (i_in.pos_x >= 0) && (int'(i_in.pos_x) < pcpd_pkg::CANVAS_WIDTH) &&
                       (i_in.pos_y >= 0) && (int'(i_in.pos_y) < pcpd_pkg::CANVAS_HEIGHT);
    assign win_inside = (i_in.pos_x >= 0) && (int'(i_in.pos_x) < pcpd_pkg::WIN_W) &&
                        (i_in.pos_y >= 0) && (int'(i_in.pos_y) < pcpd_pkg::WIN_H);

    // read scales window coords down to canvas coords
    always_comb begin
        if (i_in.func == pcpd_pkg::FN_READ) begin
            cx = pcpd_pkg::XW'($unsigned(i_in.pos_x) / pcpd_pkg::SCALE);
            cy = pcpd_pkg::YW'($unsigned(i_in.pos_y) / pcpd_pkg::SCALE);
        end else begin
            cx = pcpd_pkg::XW'($unsigned(i_in.pos_x));
            cy = pcpd_pkg::YW'($unsigned(i_in.pos_y));
        end
    end

    assign acc_addr = pcpd_pkg::ADDR_W'(int'(cy) * pcpd_pkg::ROW_BYTES + (int'(cx) >> 2));

    assign fade_cmd.start_out = in_acc && (i_in.func == pcpd_pkg::FN_FADE_OUT);
    assign fade_cmd.start_in  = in_acc && (i_in.func == pcpd_pkg::FN_FADE_IN);
    assign fade_cmd.tick      = in_acc && (i_in.func == pcpd_pkg::FN_TICK);

    pcpd_fade u_fade (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (fade_cmd),
        .i_elapsed (i_in.elapsed),
        .i_rate    (r_fade_rate),
        .o_stat    (fade_stat)
    );

    pcpd_canvas_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (acc_addr),
        .o_rdata (ram_rdata)
    );

    assign pix    = ram_rdata[2*r_sub +: 2];
    assign mapped = fade_stat.map[2*pix +: 2];

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_clr_addr    = r_clr_addr;
        n_sub         = r_sub;
        n_cidx        = r_cidx;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_rgb     = r_out_rgb;
        n_out_fading  = r_out_fading;
        n_out_outside = r_out_outside;
        ram_we        = 1'b0;
        ram_waddr     = r_addr;
        ram_wdata     = ram_rdata;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_addr = acc_addr;
                    n_sub  = cx[1:0];
                    n_cidx = i_in.color_index;
                    if (i_in.func == pcpd_pkg::FN_READ && win_inside) begin
                        n_state = ST_READ;
                    end else begin
                        // result known now; RAM work (if any) follows
                        n_out_valid   = 1'b1;
                        n_out_rgb     = '0;
                        n_out_fading  = fade_stat.fading;
                        n_out_outside = (i_in.func == pcpd_pkg::FN_READ);
                        if (i_in.func == pcpd_pkg::FN_WRITE && wr_inside) begin
                            n_state = ST_RMW;
                        end else if (i_in.func == pcpd_pkg::FN_CLEAR) begin
                            n_state    = ST_CLEAR;
                            n_clr_addr = '0;
                        end
                    end
                end
            end
            ST_RMW: begin
                ram_we = 1'b1;
                for (int p = 0; p < 4; p++) begin
                    if (2'(p) == r_sub) ram_wdata[2*p +: 2] = r_cidx;
                end
                n_state = ST_IDLE;
            end
            ST_READ: begin
                n_out_valid   = 1'b1;
                n_out_rgb     = r_color[mapped];
                n_out_fading  = fade_stat.fading;
                n_out_outside = 1'b0;
                n_state       = ST_IDLE;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = {4{r_cidx}};
                if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
                else                         n_clr_addr = r_clr_addr + pcpd_pkg::ADDR_W'(1);
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_addr        <= n_addr;
        r_clr_addr    <= n_clr_addr;
        r_sub         <= n_sub;
        r_cidx        <= n_cidx;
        r_out_rgb     <= n_out_rgb;
        r_out_fading  <= n_out_fading;
        r_out_outside <= n_out_outside;
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color[0]  <= pcpd_pkg::COLOR0_RST;
            r_color[1]  <= pcpd_pkg::COLOR1_RST;
            r_color[2]  <= pcpd_pkg::COLOR2_RST;
            r_color[3]  <= pcpd_pkg::COLOR3_RST;
            r_fade_rate <= pcpd_pkg::FADE_RATE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                pcpd_pkg::CFG_COLOR0:    r_color[0]  <= i_cfg.data;
                pcpd_pkg::CFG_COLOR1:    r_color[1]  <= i_cfg.data;
                pcpd_pkg::CFG_COLOR2:    r_color[2]  <= i_cfg.data;
                pcpd_pkg::CFG_COLOR3:    r_color[3]  <= i_cfg.data;
                pcpd_pkg::CFG_FADE_RATE: r_fade_rate <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.rgb     = r_out_rgb;
    assign o_out.fading  = r_out_fading;
    assign o_out.outside = r_out_outside;

    `ASSERT_NEXT(a_read_issue, i_clk, i_rst_n, in_acc && i_in.func == pcpd_pkg::FN_READ && win_inside, r_state == ST_READ)
    `ASSERT_IMPLIES(a_read_slot_free, i_clk, i_rst_n, r_state == ST_READ, !r_out_valid)
    `ASSERT_NEXT(a_clear_done, i_clk, i_rst_n, r_state == ST_CLEAR && r_clr_addr == LAST_ADDR, r_state == ST_IDLE)

endmodule

// ----- design/pcpd_canvas_ram.sv -----
module pcpd_canvas_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [pcpd_pkg::ADDR_W-1:0]   i_waddr,
    input  logic [7:0]                    i_wdata,
    input  logic [pcpd_pkg::ADDR_W-1:0]   i_raddr,
    output logic [7:0]                    o_rdata
);

    logic [7:0] mem [pcpd_pkg::STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/pcpd_fade.sv -----
module pcpd_fade (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcpd_pkg::t_fade_cmd   i_cmd,
    input  logic [15:0]           i_elapsed,
    input  logic [7:0]            i_rate,
    output pcpd_pkg::t_fade_stat  o_stat
);

    logic [1:0]  r_mode,  n_mode;
    logic [1:0]  r_level, n_level;
    logic [23:0] r_accum, n_accum;
    logic [7:0]  r_map,   n_map;
    logic [23:0] prod;
    logic [24:0] sum;

    assign prod = {16'd0, i_rate} * {8'd0, i_elapsed};
    assign sum  = {1'b0, r_accum} + {1'b0, prod};

    always_comb begin
        n_mode  = r_mode;
        n_level = r_level;
        n_accum = r_accum;
        n_map   = r_map;
        if (i_cmd.start_out) begin
            n_mode  = pcpd_pkg::MODE_OUT;
            n_level = 2'd0;
            n_accum = '0;
        end else if (i_cmd.start_in) begin
            n_mode  = pcpd_pkg::MODE_IN;
            n_level = 2'd3;
            n_accum = '0;
        end else if (i_cmd.tick) begin
            if (r_mode == pcpd_pkg::MODE_OUT || r_mode == pcpd_pkg::MODE_IN) begin
                n_accum = sum[23:0];
                if (sum[23:0] >= pcpd_pkg::ACC_ONE) begin
                    n_accum = '0;
                    if (r_mode == pcpd_pkg::MODE_OUT) begin
                        if (r_level < 2'd3) n_level = r_level + 2'd1;
                        else                n_mode  = pcpd_pkg::MODE_NONE;
                    end else begin
                        if (r_level > 2'd0) n_level = r_level - 2'd1;
                        else                n_mode  = pcpd_pkg::MODE_NONE;
                    end
                end
            end
            // palette reloads on every tick, fading or not
            n_map = pcpd_pkg::level_map(n_level);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pcpd_pkg::MODE_NONE;
            r_level <= 2'd0;
            r_accum <= '0;
            r_map   <= pcpd_pkg::MAP_IDENTITY;
        end else begin
            r_mode  <= n_mode;
            r_level <= n_level;
            r_accum <= n_accum;
            r_map   <= n_map;
        end
    end

    // fading reflects the state after the current command
    assign o_stat.fading = (n_mode == pcpd_pkg::MODE_OUT) || (n_mode == pcpd_pkg::MODE_IN);
    assign o_stat.map    = r_map;

endmodule

// ----- verif/pcpd_checker.sv -----
module pcpd_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pcpd_in_if   i_in,
    pcpd_out_if  i_out,
    pcpd_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import pcpd_pkg::*;

    typedef struct packed {
        logic [23:0] rgb;
        logic        fading;
        logic        outside;
    } t_pixel_result;

    logic [7:0]  canvas_bytes [STORE_BYTES] = '{default: 8'h00};
    logic [7:0]  fade_maps [4] = '{8'hE4, 8'h90, 8'h40, 8'h00};
    logic [1:0]  fade_mode;
    logic [1:0]  fade_level;
    logic [23:0] fade_accum;
    logic [7:0]  palette_map;
    logic [23:0] screen_color [4];
    logic [7:0]  fade_rate;

    t_pixel_result result_q[$];
    int            fail_count = 0;

    task automatic apply_command(input logic [2:0] func, input logic signed [11:0] px,
                                 input logic signed [11:0] py, input logic [1:0] c,
                                 input logic [15:0] el);
        t_pixel_result r;
        int            ux;
        int            uy;
        int            idx;
        logic [1:0]    v;
        logic [1:0]    m;
        logic [31:0]   sum;
        r = '0;
        case (func)
            FN_WRITE: begin
                if (px >= 0 && px < CANVAS_WIDTH && py >= 0 && py < CANVAS_HEIGHT) begin
                    ux  = int'(px);
                    uy  = int'(py);
                    idx = uy * ROW_BYTES + ux / 4;
                    canvas_bytes[idx][2 * (ux % 4) +: 2] = c;
                end
            end
            FN_CLEAR: begin
                foreach (canvas_bytes[i]) canvas_bytes[i] = {4{c}};
            end
            FN_FADE_OUT: begin
                fade_mode  = MODE_OUT;
                fade_level = 2'd0;
                fade_accum = '0;
            end
            FN_FADE_IN: begin
                fade_mode  = MODE_IN;
                fade_level = 2'd3;
                fade_accum = '0;
            end
            FN_TICK: begin
                if (fade_mode == MODE_OUT || fade_mode == MODE_IN) begin
                    sum        = 32'(fade_accum) + 32'(fade_rate) * 32'(el);
                    fade_accum = sum[23:0];
                    if (fade_accum >= ACC_ONE) begin
                        fade_accum = '0;
                        if (fade_mode == MODE_OUT) begin
                            if (fade_level < 2'd3) fade_level = fade_level + 2'd1;
                            else fade_mode = MODE_NONE;
                        end else begin
                            if (fade_level > 2'd0) fade_level = fade_level - 2'd1;
                            else fade_mode = MODE_NONE;
                        end
                    end
                end
                palette_map = fade_maps[fade_level];
            end
            FN_READ: begin
                if (px < 0 || px >= WIN_W || py < 0 || py >= WIN_H) begin
                    r.outside = 1'b1;
                end else begin
                    ux    = int'(px) / SCALE;
                    uy    = int'(py) / SCALE;
                    idx   = uy * ROW_BYTES + ux / 4;
                    v     = canvas_bytes[idx][2 * (ux % 4) +: 2];
                    m     = palette_map[2 * v +: 2];
                    r.rgb = screen_color[m];
                end
            end
            default: ;
        endcase
        r.fading = (fade_mode == MODE_OUT || fade_mode == MODE_IN);
        result_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_pixel_result exp_r;
        if (!i_rst_n) begin
            // canvas survives reset
            fade_mode       = MODE_NONE;
            fade_level      = 2'd0;
            fade_accum      = '0;
            palette_map     = MAP_IDENTITY;
            screen_color[0] = COLOR0_RST;
            screen_color[1] = COLOR1_RST;
            screen_color[2] = COLOR2_RST;
            screen_color[3] = COLOR3_RST;
            fade_rate       = FADE_RATE_RST;
            result_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    CFG_COLOR0:    screen_color[0] = i_cfg.data;
                    CFG_COLOR1:    screen_color[1] = i_cfg.data;
                    CFG_COLOR2:    screen_color[2] = i_cfg.data;
                    CFG_COLOR3:    screen_color[3] = i_cfg.data;
                    CFG_FADE_RATE: fade_rate       = i_cfg.data[7:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                apply_command(i_in.func, i_in.pos_x, i_in.pos_y, i_in.color_index,
                              i_in.elapsed);
            end
            if (i_out.valid && i_out.ready) begin
                if (result_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected transaction, expected none, %s",
                             $time, "got:");
                    $display("    rgb=%h fading=%b outside=%b",
                             i_out.rgb, i_out.fading, i_out.outside);
                end else begin
                    exp_r = result_q.pop_front();
                    if (i_out.rgb !== exp_r.rgb) begin
                        fail_count++;
                        $display("%0t: rgb expected %h, got %h", $time, exp_r.rgb, i_out.rgb);
                    end
                    if (i_out.fading !== exp_r.fading) begin
                        fail_count++;
                        $display("%0t: fading expected %b, got %b",
                                 $time, exp_r.fading, i_out.fading);
                    end
                    if (i_out.outside !== exp_r.outside) begin
                        fail_count++;
                        $display("%0t: outside expected %b, got %b",
                                 $time, exp_r.outside, i_out.outside);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= result_q.size();
    end

endmodule

// ----- verif/packed_canvas_palette_display_test.sv -----
module packed_canvas_palette_display_test;
    import pcpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    // covers a clear sweep still running after its transaction has come back
    localparam int SETTLE_CYCLES  = STORE_BYTES + 100;

    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    pcpd_in_if  in_ch ();
    pcpd_out_if out_ch ();
    pcpd_cfg_if cfg_ch ();

    packed_canvas_palette_display i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pcpd_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stalls
    initial begin
        forever begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_cmd(input logic [2:0] f, input logic signed [11:0] x,
                            input logic signed [11:0] y, input logic [1:0] c,
                            input logic [15:0] e);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= f;
        in_ch.pos_x       <= x;
        in_ch.pos_y       <= y;
        in_ch.color_index <= c;
        in_ch.elapsed     <= e;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [23:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= addr;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_palette(input logic [23:0] c0, input logic [23:0] c1,
                                   input logic [23:0] c2, input logic [23:0] c3,
                                   input logic [7:0] rate);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(CFG_COLOR0, c0);
        cfg_write(CFG_COLOR1, c1);
        cfg_write(CFG_COLOR2, c2);
        cfg_write(CFG_COLOR3, c3);
        cfg_write(CFG_FADE_RATE, {16'h0, rate});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_cmd();
        int                 sel;
        int                 spot;
        logic [2:0]         f;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [1:0]         c;
        logic [15:0]        e;
        sel  = $urandom_range(0, 199);
        spot = $urandom_range(0, 9);
        c    = 2'($urandom);
        x    = 12'($urandom);
        y    = 12'($urandom);
        e    = 16'($urandom);
        if (sel < 2) f = FN_CLEAR;
        else if (sel < 62) f = FN_WRITE;
        else if (sel < 132) f = FN_READ;
        else if (sel < 178) f = FN_TICK;
        else if (sel < 186) f = FN_FADE_OUT;
        else if (sel < 194) f = FN_FADE_IN;
        else f = 3'($urandom_range(6, 7));
        // concentrate writes and reads on a small patch so reads see varied content
        if (f == FN_WRITE && spot < 6) begin
            x = 12'($urandom_range(0, 15));
            y = 12'($urandom_range(0, 15));
        end else if (f == FN_WRITE && spot < 9) begin
            x = 12'($urandom_range(0, CANVAS_WIDTH - 1));
            y = 12'($urandom_range(0, CANVAS_HEIGHT - 1));
        end else if (f == FN_READ && spot < 6) begin
            x = 12'($urandom_range(0, 16 * SCALE - 1));
            y = 12'($urandom_range(0, 16 * SCALE - 1));
        end else if (f == FN_READ && spot < 9) begin
            x = 12'($urandom_range(0, WIN_W - 1));
            y = 12'($urandom_range(0, WIN_H - 1));
        end
        if (f == FN_TICK && spot < 3) e = 16'($urandom_range(0, 4095));
        else if (f == FN_TICK && spot == 3) e = '0;
        send_cmd(f, x, y, c, e);
    endtask

    task automatic run_random(input int count, input int calm_tail);
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (count - i <= calm_tail) idle_pct = 0;
            if ($urandom_range(0, 99) == 0) drain_results();
            send_random_cmd();
        end
    endtask

    initial begin
        idle_pct           = 20;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= FN_WRITE;
        in_ch.pos_x       <= '0;
        in_ch.pos_y       <= '0;
        in_ch.color_index <= '0;
        in_ch.elapsed     <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.addr       <= CFG_COLOR0;
        cfg_ch.data       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // the canvas holds garbage until the first clear
        send_cmd(FN_CLEAR, 12'sd0, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_WRITE, 12'sd0, 12'sd0, 2'd3, 16'd0);
        send_cmd(FN_WRITE, 12'sd127, 12'sd127, 2'd2, 16'd0);
        send_cmd(FN_WRITE, 12'sd1, 12'sd0, 2'd1, 16'd0);
        send_cmd(FN_WRITE, -12'sd1, 12'sd5, 2'd3, 16'd0);
        send_cmd(FN_WRITE, 12'sd128, 12'sd0, 2'd3, 16'd0);
        send_cmd(FN_WRITE, 12'sd2047, -12'sd2048, 2'd1, 16'hFFFF);
        send_cmd(FN_READ, 12'sd0, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_READ, 12'sd511, 12'sd511, 2'd0, 16'd0);
        send_cmd(FN_READ, 12'sd4, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_READ, -12'sd1, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_READ, 12'sd512, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_READ, 12'sd0, 12'sd512, 2'd0, 16'd0);
        send_cmd(FN_READ, -12'sd2048, 12'sd2047, 2'd3, 16'hFFFF);
        send_cmd(3'd6, 12'sd3, 12'sd3, 2'd1, 16'd1);
        send_cmd(3'd7, -12'sd1, -12'sd1, 2'd3, 16'hFFFF);
        send_cmd(FN_FADE_OUT, 12'sd0, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_TICK, 12'sd0, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_TICK, 12'sd0, 12'sd0, 2'd0, 16'hFFFF);
        send_cmd(FN_READ, 12'sd0, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_TICK, 12'sd0, 12'sd0, 2'd0, 16'hFFFF);
        send_cmd(FN_FADE_IN, 12'sd0, 12'sd0, 2'd0, 16'd0);
        send_cmd(FN_TICK, 12'sd0, 12'sd0, 2'd0, 16'hFFFF);
        send_cmd(FN_READ, 12'sd5, 12'sd1, 2'd0, 16'd0);
        send_cmd(FN_CLEAR, 12'sd0, 12'sd0, 2'd3, 16'd0);

        program_palette(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                        8'($urandom));
        run_random(250, 0);
        program_palette(24'h000000, 24'h000000, 24'h000000, 24'h000000, 8'd0);
        run_random(150, 0);
        program_palette(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd255);
        run_random(150, 0);
        program_palette(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 8'd1);
        run_random(200, 0);
        program_palette(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                        8'($urandom));
        run_random(250, 150);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
